### design/top_k_score_selector_unit_assert.svh
// ---------------------------------------------------------------------------
// Top-k score selector assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_UNIT_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TKS_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TKS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tks_pkg.sv
// ---------------------------------------------------------------------------
// tks_pkg
// Sizes, list entry type and controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

    localparam int TOPK_MAX    = 5;
    localparam int NUM_CLASSES = 64;
    localparam int TOPK_RESET  = 5;

    localparam int K_W     = 3;   // top_k register and rank field
    localparam int SCORE_W = 15;  // input score
    localparam int BEST_W  = 16;  // stored/emitted score, signed
    localparam int CLSID_W = 6;   // class_id field
    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W   = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;

    typedef struct packed {
        logic [CLS_W-1:0]         cls;
        logic signed [BEST_W-1:0] score;
    } entry_t;

    typedef struct packed {
        logic accept;  // take one score into the list
        logic emit;    // present the entry at the emit index
        logic clear;   // restore the sentinel list
    } cmd_t;

    typedef struct packed {
        logic last_rank;  // emit index sits on entry top_k-1
    } status_t;

    localparam entry_t SENTINEL = '{cls: '0, score: -16'sd1};

    function automatic logic [K_W-1:0] limit_k(input logic [K_W-1:0] v);
        logic [K_W-1:0] r;
        r = v;
        if (v == '0)
            r = K_W'(1);
        else if (int'(v) > TOPK_MAX)
            r = K_W'(TOPK_MAX);
        return r;
    endfunction

endpackage

`default_nettype wire

### design/tks_ctrl.sv
// ---------------------------------------------------------------------------
// tks_ctrl
// Sequencer: takes scores while idle, walks the list out after the last one.
// ---------------------------------------------------------------------------
`default_nettype none

module tks_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           last_item,
    input  wire tks_pkg::status_t status,
    output tks_pkg::cmd_t       cmd,
    output logic                busy
);

    typedef enum logic {
        IDLE,
        EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            IDLE:
            begin
                cmd.accept = start;
                if (start && last_item)
                begin
                    state_next = EMIT;
                    busy_next  = 1'b1;
                end
            end
            EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.last_rank)
                begin
                    // list is out: clear it and reopen
                    cmd.clear  = 1'b1;
                    state_next = IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

### design/tks_datapath.sv
// ---------------------------------------------------------------------------
// tks_datapath
// Ranked list with parallel insertion, class counter and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tks_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tks_pkg::cmd_t                      cmd,
    output tks_pkg::status_t                        status,
    input  wire logic [tks_pkg::K_W-1:0]            top_k,
    input  wire logic [tks_pkg::SCORE_W-1:0]        score,
    input  wire logic                               last_item,
    output logic                                    result_strobe,
    output logic [tks_pkg::K_W-1:0]                 rank,
    output logic [tks_pkg::CLSID_W-1:0]             class_id,
    output logic signed [tks_pkg::BEST_W-1:0]       best_score,
    output logic                                    last_result
);

    tks_pkg::entry_t                     list_reg  [tks_pkg::TOPK_MAX];
    tks_pkg::entry_t                     list_next [tks_pkg::TOPK_MAX];
    logic [tks_pkg::CLS_W-1:0]           cnt_reg;
    logic [tks_pkg::IDX_W-1:0]           idx_reg;
    logic                                strobe_reg;
    logic [tks_pkg::K_W-1:0]             rank_reg;
    logic [tks_pkg::CLSID_W-1:0]         class_reg;
    logic signed [tks_pkg::BEST_W-1:0]   score_reg;
    logic                                last_reg;

    logic [tks_pkg::IDX_W-1:0]           last_pos;
    logic signed [tks_pkg::BEST_W-1:0]   sc_ext;
    logic                                enter;
    logic [tks_pkg::IDX_W-1:0]           pos;

    assign last_pos = tks_pkg::IDX_W'(top_k - tks_pkg::K_W'(1));
    assign sc_ext   = signed'({1'b0, score});
    assign enter    = cmd.accept && (list_reg[last_pos].score < sc_ext);

    assign status.last_rank = (idx_reg == last_pos);

    // Slot for the new score: just below the deepest kept entry that is not smaller.
    always_comb
    begin
        pos = '0;
        for (int j = 0; j < tks_pkg::TOPK_MAX - 1; j++)
        begin
            if ((j + 1 < int'(top_k)) && (list_reg[j].score >= sc_ext))
                pos = tks_pkg::IDX_W'(j + 1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < tks_pkg::TOPK_MAX; i++)
        begin
            list_next[i] = list_reg[i];
            if (cmd.clear)
                list_next[i] = tks_pkg::SENTINEL;
            else if (enter && (i < int'(top_k)))
            begin
                if (i == int'(pos))
                begin
                    list_next[i].cls   = cnt_reg;
                    list_next[i].score = sc_ext;
                end
                else if (i > int'(pos))
                    list_next[i] = list_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tks_pkg::TOPK_MAX; i++)
                list_reg[i] <= tks_pkg::SENTINEL;
        end
        else
        begin
            for (int i = 0; i < tks_pkg::TOPK_MAX; i++)
                list_reg[i] <= list_next[i];
        end
    end

    // Class counter: wrap at the class count, restart after the last score.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.accept)
        begin
            if (last_item || (cnt_reg == tks_pkg::CLS_W'(tks_pkg::NUM_CLASSES - 1)))
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + tks_pkg::CLS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.emit)
                idx_reg <= status.last_rank ? '0 : idx_reg + tks_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rank_reg  <= tks_pkg::K_W'(idx_reg);
            class_reg <= tks_pkg::CLSID_W'(list_reg[idx_reg].cls);
            score_reg <= list_reg[idx_reg].score;
            last_reg  <= status.last_rank;
        end
    end

    assign result_strobe = strobe_reg;
    assign rank          = rank_reg;
    assign class_id      = class_reg;
    assign best_score    = score_reg;
    assign last_result   = last_reg;

endmodule

`default_nettype wire

### design/top_k_score_selector_unit.sv
// ---------------------------------------------------------------------------
// top_k_score_selector_unit
// Keeps the top_k best class scores and reports them after the last score.
// ---------------------------------------------------------------------------
// A score is taken on any cycle with start high and busy low, one per cycle;
// its class index is its position in the set. The score flagged last_item
// is ranked like the others and then busy rises while the top_k kept
// entries walk out through the result register, best first, one word per
// cycle on result_strobe, ending with last_result. Once the last score is
// taken, EMIT loads each word into the result register on the ports; the
// receiver cannot stall, so every word must be taken in the cycle it is
// shown. Unfilled ranks read class 0, score -1. The next set may start in
// the cycle that carries the final word.
// top_k must be written via the cfg channel (always ready) only while idle; the
// block does not check. Writes of 0 give 1, writes above the list depth the depth.
// ---------------------------------------------------------------------------
`default_nettype none

`include "top_k_score_selector_unit_assert.svh"

module top_k_score_selector_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [tks_pkg::SCORE_W-1:0]        score,
    input  wire logic                               last_item,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tks_pkg::K_W-1:0]            cfg_data,
    output logic                                    result_strobe,
    output logic [tks_pkg::K_W-1:0]                 rank,
    output logic [tks_pkg::CLSID_W-1:0]             class_id,
    output logic signed [tks_pkg::BEST_W-1:0]       best_score,
    output logic                                    last_result
);

    logic [tks_pkg::K_W-1:0] top_k_reg;
    tks_pkg::cmd_t           cmd;
    tks_pkg::status_t        status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_k_reg <= tks_pkg::limit_k(tks_pkg::K_W'(tks_pkg::TOPK_RESET));
        else if (cfg_valid && cfg_ready)
            top_k_reg <= tks_pkg::limit_k(cfg_data);
    end

    tks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    tks_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .top_k         (top_k_reg),
        .score         (score),
        .last_item     (last_item),
        .result_strobe (result_strobe),
        .rank          (rank),
        .class_id      (class_id),
        .best_score    (best_score),
        .last_result   (last_result)
    );

    `TKS_ASSERT_NEXT(a_last_starts_emit, clk, rst_n, start && !busy && last_item, busy,
        "last score did not start emission")

    `TKS_ASSERT_NEXT(a_list_no_gap, clk, rst_n, result_strobe && !last_result, result_strobe,
        "gap inside emitted list")

    `TKS_ASSERT_NOW(a_idle_on_final, clk, rst_n, result_strobe && last_result, !busy,
        "still busy on final result word")

endmodule

`default_nettype wire
